// ===== src/adsr_envelope_multichannel_macros.svh =====
// Assertion macros shared by the envelope generator's checkers.
// Each macro expands to one labelled concurrent assertion on a clock and an active-low reset.
`ifndef ADSR_ENVELOPE_MULTICHANNEL_MACROS_SVH
`define ADSR_ENVELOPE_MULTICHANNEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("adsr checker: property violated");

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("adsr checker: property violated");

`endif

// ===== src/adsr_pkg.sv =====
// Types and constants shared by the envelope generator's modules.
// No dependencies.
`timescale 1ns / 1ps

package adsr_pkg;

	// Field widths of the channel words and registers.
	localparam int VOICE_W    = 4;
	localparam int OP_W       = 2;
	localparam int LVL_W      = 24;
	localparam int LVL_INT_W  = 8;
	localparam int ATT_W      = 10;
	localparam int MS_W       = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Step arithmetic: (span * 45) / (ms * 1000).
	localparam int TICK_US   = 45;
	localparam int MS_SCALE  = 1000;
	localparam int DVD_W     = 30;
	localparam int DVS_W     = 22;
	localparam int DIV_CNT_W = 5;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK    = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ATTACK,
		PH_DECAY,
		PH_RELEASE
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_IGNORE
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_UPDATE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_div;
		logic div_step;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

// ===== src/adsr_if.sv =====
// Valid/ready channel interfaces for the envelope generator's input and result words.
// Depends on adsr_pkg for the field widths.
`timescale 1ns / 1ps

interface adsr_in_if import adsr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VOICE_W-1:0] voice;
	logic [OP_W-1:0]    operation;
	logic               wave_at_zero;

	modport source(output valid, voice, operation, wave_at_zero, input ready);
	modport sink(input valid, voice, operation, wave_at_zero, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VOICE_W-1:0] voice_out;
	logic [LVL_W-1:0]   level;
	logic [1:0]         phase;

	modport source(output valid, voice_out, level, phase, input ready);
	modport sink(input valid, voice_out, level, phase, output ready);
endinterface

// ===== src/adsr_envelope_multichannel.sv =====
// Multichannel attack-decay-sustain-release envelope generator.
//
// Input channel in_ch carries one word per item: a channel number, an operation (tick,
// note-on, note-off, or a fourth code that only reports) and the waveform-at-zero flag.
// Each accepted word yields exactly one result word on out_ch: the channel number and the
// channel's level (unsigned 8.16) and phase after the item. A word is taken when valid and
// ready are both high. The user must write the registers over cfg_write/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. One item is processed at a time:
// the word is captured, evaluated, run through the step divider if it is a ramping tick, and
// its result is loaded into the output register as the controller returns to idle, where the
// next word is accepted. The step divider is restoring, one quotient bit per cycle.
// The result sits in an output register; while the receiver stalls, the next word can be
// accepted and worked on, and its result waits until that register is free.
// Reset (arst_n, asynchronous) loads the register defaults and marks every channel as
// silent and inactive at once; no clearing pass is needed.
`timescale 1ns / 1ps

module adsr_envelope_multichannel import adsr_pkg::*; #(
	parameter int VOICES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	adsr_in_if.sink               in_ch,
	adsr_out_if.source            out_ch,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	adsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	adsr_dp #(
		.VOICES (VOICES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_voice        (in_ch.voice),
		.in_operation    (in_ch.operation),
		.in_wave_at_zero (in_ch.wave_at_zero),
		.out_voice_out   (out_ch.voice_out),
		.out_level       (out_ch.level),
		.out_phase       (out_ch.phase)
	);

endmodule

// ===== src/adsr_div.sv =====
// Restoring divider that retires one quotient bit per cycle in which step is high.
// Depends on adsr_pkg for the operand widths.
`timescale 1ns / 1ps

module adsr_div import adsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             step,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 fits;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Operands and partial remainder; the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	// Bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done     = step && (cnt_q == DIV_CNT_W'(DVD_W - 1));
	assign quotient = quo_q;

endmodule

// ===== src/adsr_dp.sv =====
// Datapath of the envelope generator: registers, per-channel stores, step divider and result word.
// Depends on adsr_pkg and adsr_div.
`timescale 1ns / 1ps

module adsr_dp import adsr_pkg::*; #(
	parameter int VOICES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [VOICE_W-1:0]    in_voice,
	input  logic [OP_W-1:0]       in_operation,
	input  logic                  in_wave_at_zero,
	output logic [VOICE_W-1:0]    out_voice_out,
	output logic [LVL_W-1:0]      out_level,
	output logic [1:0]            out_phase
);

	localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [LVL_W-1:0] LVL_MAX = '1;

	// Configuration registers.
	logic [ATT_W-1:0]     attack_ms_q;
	logic [MS_W-1:0]      decay_ms_q;
	logic [MS_W-1:0]      release_ms_q;
	logic [LVL_INT_W-1:0] sustain_q;
	logic [LVL_INT_W-1:0] peak_q;

	// Per-channel stores.
	logic [LVL_W-1:0]  level_mem [VOICES];
	phase_t            phase_mem [VOICES];
	logic [LVL_W-1:0]  rs_mem    [VOICES];
	logic [VOICES-1:0] entry_valid_q;

	// Current item and the channel state read for it.
	logic [VOICE_W-1:0] voice_q;
	op_t                op_q;
	logic               waz_q;
	logic               in_range_q;
	logic [LVL_W-1:0]   lvl_rd_q;
	phase_t             ph_rd_q;
	logic [LVL_W-1:0]   rs_rd_q;
	logic               vld_rd_q;

	// Result word.
	logic [VOICE_W-1:0] voice_out_q;
	logic [LVL_W-1:0]   level_out_q;
	phase_t             phase_out_q;

	logic [IDX_W-1:0] addr_in;
	logic [IDX_W-1:0] addr_q;
	logic [LVL_W-1:0] lvl_cur;
	phase_t           ph_cur;
	logic [LVL_W-1:0] peak_lvl;
	logic [LVL_W-1:0] sus_lvl;
	logic [LVL_W-1:0] span;
	logic [MS_W-1:0]  ms;
	logic             need_div;
	logic [DVD_W-1:0] dividend;
	logic [DVS_W-1:0] divisor;
	logic [DVD_W-1:0] quo;
	logic             div_done;
	logic [LVL_W-1:0] step_sz;
	logic [LVL_W-1:0] nlvl;
	phase_t           nph;
	logic             wr_en;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_ms_q  <= ATT_W'(200);
			decay_ms_q   <= MS_W'(1000);
			release_ms_q <= MS_W'(1000);
			sustain_q    <= LVL_INT_W'(100);
			peak_q       <= LVL_INT_W'(255);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ATTACK:  attack_ms_q  <= cfg_data[ATT_W-1:0];
				CFG_DECAY:   decay_ms_q   <= cfg_data[MS_W-1:0];
				CFG_RELEASE: release_ms_q <= cfg_data[MS_W-1:0];
				CFG_SUSTAIN: sustain_q    <= cfg_data[LVL_INT_W-1:0];
				CFG_PEAK:    peak_q       <= cfg_data[LVL_INT_W-1:0];
				default: ;
			endcase
		end
	end

	assign addr_in  = IDX_W'(in_voice);
	assign addr_q   = IDX_W'(voice_q);
	assign peak_lvl = {peak_q, 16'h0000};
	assign sus_lvl  = {sustain_q, 16'h0000};
	assign wr_en    = cmd.commit && in_range_q;

	// Capture the input word.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			voice_q    <= in_voice;
			op_q       <= op_t'(in_operation);
			waz_q      <= in_wave_at_zero;
			in_range_q <= (32'(in_voice) < VOICES);
			vld_rd_q   <= entry_valid_q[addr_in];
		end
	end

	// Channel stores: registered read on capture, write back on commit.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lvl_rd_q <= level_mem[addr_in];
			ph_rd_q  <= phase_mem[addr_in];
			rs_rd_q  <= rs_mem[addr_in];
		end
		if (wr_en) begin
			level_mem[addr_q] <= nlvl;
			phase_mem[addr_q] <= nph;
		end
		if (wr_en && (op_q == OP_NOTE_OFF)) begin
			rs_mem[addr_q] <= lvl_cur;
		end
	end

	// A channel never written since reset reads as silent and inactive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[addr_q] <= 1'b1;
		end
	end

	assign lvl_cur = vld_rd_q ? lvl_rd_q : '0;
	assign ph_cur  = vld_rd_q ? ph_rd_q : PH_IDLE;

	// Decide whether this tick ramps, and pick the span and time for its step.
	always_comb begin
		span     = peak_lvl;
		ms       = MS_W'(attack_ms_q);
		need_div = 1'b0;
		if ((op_q == OP_TICK) && in_range_q) begin
			unique case (ph_cur)
				PH_ATTACK: begin
					need_div = (attack_ms_q != '0) && (lvl_cur < peak_lvl);
				end
				PH_DECAY: begin
					ms       = decay_ms_q;
					need_div = (decay_ms_q != '0) && (lvl_cur > sus_lvl);
				end
				PH_RELEASE: begin
					span     = rs_rd_q;
					ms       = release_ms_q;
					need_div = (release_ms_q != '0) && (lvl_cur != '0);
				end
				PH_IDLE: ;
			endcase
		end
	end

	// Scale both operands by constants; the products are registered inside the divider.
	assign dividend = DVD_W'(span) * DVD_W'(TICK_US);
	assign divisor  = DVS_W'(ms) * DVS_W'(MS_SCALE);

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load_div),
		.step     (cmd.div_step),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.need_div = need_div;
	assign status.div_done = div_done;

	// A step that truncates to zero still moves by one LSB.
	always_comb begin
		if (quo == '0) begin
			step_sz = LVL_W'(1);
		end else if (quo > DVD_W'(LVL_MAX)) begin
			step_sz = LVL_MAX;
		end else begin
			step_sz = quo[LVL_W-1:0];
		end
	end

	// New level and phase of the channel.
	always_comb begin
		nlvl = lvl_cur;
		nph  = ph_cur;
		unique case (op_q)
			OP_TICK: begin
				unique case (ph_cur)
					PH_ATTACK: begin
						if (attack_ms_q == '0) begin
							nlvl = peak_lvl;
							nph  = PH_DECAY;
						end else if (lvl_cur < peak_lvl) begin
							nlvl = (peak_lvl - lvl_cur <= step_sz) ? peak_lvl : lvl_cur + step_sz;
						end else begin
							nph = PH_DECAY;
						end
					end
					PH_DECAY: begin
						if (decay_ms_q == '0) begin
							nlvl = sus_lvl;
						end else if (lvl_cur > sus_lvl) begin
							nlvl = (lvl_cur - sus_lvl <= step_sz) ? sus_lvl : lvl_cur - step_sz;
						end
					end
					PH_RELEASE: begin
						if (release_ms_q == '0) begin
							if (waz_q) begin
								nlvl = '0;
								nph  = PH_IDLE;
							end
						end else if (lvl_cur != '0) begin
							nlvl = (lvl_cur <= step_sz) ? '0 : lvl_cur - step_sz;
						end else begin
							nph = PH_IDLE;
						end
					end
					PH_IDLE: ;
				endcase
			end
			OP_NOTE_ON:  nph = PH_ATTACK;
			OP_NOTE_OFF: nph = PH_RELEASE;
			OP_IGNORE:   ;
		endcase
	end

	// Result word; a channel outside the store reports silence.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			voice_out_q <= voice_q;
			level_out_q <= in_range_q ? nlvl : '0;
			phase_out_q <= in_range_q ? nph : PH_IDLE;
		end
	end

	assign out_voice_out = voice_out_q;
	assign out_level     = level_out_q;
	assign out_phase     = phase_out_q;

endmodule

// ===== src/adsr_ctrl.sv =====
// Controller state machine of the envelope generator and the result word's valid flag.
// Depends on adsr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module adsr_ctrl import adsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	// The result register is free when empty or being emptied this cycle.
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_EVAL;
			ST_EVAL:   state_d = status.need_div ? ST_DIV : ST_UPDATE;
			ST_DIV:    if (status.div_done) state_d = ST_UPDATE;
			ST_UPDATE: if (out_free) state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.load_div = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL:   cmd.load_div = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_UPDATE: cmd.commit   = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/adsr_checker.sv =====
// Port-level checker for the envelope generator, bound to its top level.
// Depends on adsr_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "adsr_envelope_multichannel_macros.svh"

module adsr_checker import adsr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VOICE_W-1:0] out_voice_out,
	input logic [LVL_W-1:0]   out_level,
	input logic [1:0]         out_phase
);

	logic                       in_acc;
	logic                       out_stall;
	logic [VOICE_W+LVL_W+1:0]   out_word;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_word  = {out_voice_out, out_level, out_phase};

	// A stalled result word stays offered and unchanged.
	`ADSR_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid)
	`ADSR_ASSERT_NXT(a_out_stable, clk, arst_n, out_stall, $stable(out_word))

	// Only one word is in work: the input closes right after an acceptance.
	`ADSR_ASSERT_NXT(a_one_in_work, clk, arst_n, in_acc, !in_ready)

	// No result can be produced in the cycle straight after an acceptance.
	`ADSR_ASSERT_NXT(a_min_latency, clk, arst_n, in_acc, !$rose(out_valid))

	// A new result is loaded only while the input is closed.
	`ADSR_ASSERT_IMP(a_load_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind adsr_envelope_multichannel adsr_checker u_adsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_voice_out (out_ch.voice_out),
	.out_level     (out_ch.level),
	.out_phase     (out_ch.phase)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the multichannel envelope generator.
// Drives note and tick words with bursty feed and a stalling receiver, predicts each report
// from its own envelope model and compares it field by field. Depends on adsr_pkg and adsr_if.
`timescale 1ns / 1ps

module testbench;
	import adsr_pkg::*;

	localparam int CHANNELS     = 16;
	localparam int TARGET_WORDS = 1300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 40;
	localparam int MAX_REPORTED = 10;

	// One expected report word: channel, level and phase after the item.
	typedef struct {
		logic [VOICE_W-1:0] voice;
		logic [LVL_W-1:0]   level;
		phase_t             phase;
	} env_report_t;

	logic clk;
	logic arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adsr_in_if  in_ch();
	adsr_out_if out_ch();

	adsr_envelope_multichannel #(.VOICES(CHANNELS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Envelope model state and its copy of the registers.
	logic [LVL_W-1:0] chan_level [CHANNELS];
	phase_t           chan_phase [CHANNELS];
	logic [LVL_W-1:0] chan_release_from [CHANNELS];
	logic [ATT_W-1:0] att_q;
	logic [MS_W-1:0]  dec_q;
	logic [MS_W-1:0]  rel_q;
	logic [7:0]       sus_q;
	logic [7:0]       peak_q;

	env_report_t awaited_reports[$];

	int  words_sent;
	int  reports_checked;
	int  fault_count;
	int  settings_applied;
	int  notes_silenced;
	int  burst_left;
	bit  offering;
	bit  steady_feed;
	bit  hold_request;

	// Clock: 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Per-tick ramp increment, truncated, at least one LSB and at most full scale.
	function automatic logic [LVL_W-1:0] ramp_increment(input logic [LVL_W-1:0] span,
			input logic [MS_W-1:0] ms);
		logic [63:0] q;
		q = (64'(span) * 64'(TICK_US)) / (64'(ms) * 64'(MS_SCALE));
		if (q == 64'd0)
			q = 64'd1;
		if (q > 64'hFF_FFFF)
			q = 64'hFF_FFFF;
		return q[LVL_W-1:0];
	endfunction

	// Applies one word to the model and returns the report it must produce.
	function automatic env_report_t advance_envelope(input logic [VOICE_W-1:0] v,
			input op_t op, input logic wz);
		env_report_t      r;
		logic [LVL_W-1:0] lvl;
		logic [LVL_W-1:0] peak;
		logic [LVL_W-1:0] sus;
		logic [LVL_W-1:0] st;
		lvl  = chan_level[v];
		peak = {peak_q, 16'h0000};
		sus  = {sus_q, 16'h0000};
		case (op)
			OP_TICK: begin
				case (chan_phase[v])
					PH_ATTACK: begin
						if (att_q == '0) begin
							lvl = peak;
							chan_phase[v] = PH_DECAY;
						end else if (lvl < peak) begin
							st  = ramp_increment(peak, MS_W'(att_q));
							lvl = (peak - lvl <= st) ? peak : lvl + st;
						end else begin
							chan_phase[v] = PH_DECAY;
						end
					end
					PH_DECAY: begin
						if (dec_q == '0) begin
							lvl = sus;
						end else if (lvl > sus) begin
							st  = ramp_increment(peak, dec_q);
							lvl = (lvl - sus <= st) ? sus : lvl - st;
						end
					end
					PH_RELEASE: begin
						if (rel_q == '0) begin
							if (wz) begin
								lvl = '0;
								chan_phase[v] = PH_IDLE;
								notes_silenced++;
							end
						end else if (lvl > '0) begin
							st  = ramp_increment(chan_release_from[v], rel_q);
							lvl = (lvl <= st) ? '0 : lvl - st;
						end else begin
							chan_phase[v] = PH_IDLE;
							notes_silenced++;
						end
					end
					default: begin
					end
				endcase
				chan_level[v] = lvl;
			end
			OP_NOTE_ON: begin
				chan_phase[v] = PH_ATTACK;
			end
			OP_NOTE_OFF: begin
				chan_release_from[v] = chan_level[v];
				chan_phase[v] = PH_RELEASE;
			end
			default: begin
			end
		endcase
		r.voice = v;
		r.level = chan_level[v];
		r.phase = chan_phase[v];
		return r;
	endfunction

	task automatic record_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTED)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Offers one word, waits for it to be taken, then keeps or breaks the burst.
	task automatic send_word(input logic [VOICE_W-1:0] v, input op_t op, input logic wz);
		in_ch.valid        <= 1'b1;
		in_ch.voice        <= v;
		in_ch.operation    <= op;
		in_ch.wave_at_zero <= wz;
		offering = 1'b1;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		awaited_reports.push_back(advance_envelope(v, op, wz));
		words_sent++;
		if (!steady_feed) begin
			if (burst_left == 0) begin
				in_ch.valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(40, 1)) @(posedge clk);
				burst_left = $urandom_range(12, 0);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stops offering and waits until every report has come back.
	task automatic wait_idle();
		if (offering) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all five registers back to back while the block is idle.
	task automatic apply_settings(input logic [ATT_W-1:0] att, input logic [MS_W-1:0] dec,
			input logic [MS_W-1:0] rel, input logic [7:0] sus, input logic [7:0] pk);
		logic [CFG_IDX_W-1:0]  reg_idx [5];
		logic [CFG_DATA_W-1:0] reg_val [5];
		reg_idx = '{CFG_ATTACK, CFG_DECAY, CFG_RELEASE, CFG_SUSTAIN, CFG_PEAK};
		reg_val[0] = CFG_DATA_W'(att);
		reg_val[1] = CFG_DATA_W'(dec);
		reg_val[2] = CFG_DATA_W'(rel);
		reg_val[3] = CFG_DATA_W'(sus);
		reg_val[4] = CFG_DATA_W'(pk);
		wait_idle();
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= reg_idx[i];
			cfg_data  <= reg_val[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		att_q  = att;
		dec_q  = dec;
		rel_q  = rel;
		sus_q  = sus;
		peak_q = pk;
		settings_applied++;
	endtask

	// A tick on the playing channel, or now and then a stray word on any channel.
	task automatic envelope_tick(input logic [VOICE_W-1:0] v);
		if ($urandom_range(9) != 0)
			send_word(v, OP_TICK, 1'($urandom_range(1)));
		else
			send_word(VOICE_W'($urandom_range(CHANNELS - 1)), op_t'($urandom_range(3)),
				1'($urandom_range(1)));
	endtask

	// One note: on, held for some ticks, off, then a release tail. Sometimes the note-on
	// is left out to exercise a release that starts from wherever the channel stands.
	task automatic play_note(input logic [VOICE_W-1:0] v, input int hold, input int tail);
		if ($urandom_range(6) != 0)
			send_word(v, OP_NOTE_ON, 1'($urandom_range(1)));
		repeat (hold) envelope_tick(v);
		send_word(v, OP_NOTE_OFF, 1'($urandom_range(1)));
		repeat (tail) envelope_tick(v);
	endtask

	// A ramp time: often zero or very short, now and then anywhere up to the maximum.
	function automatic int pick_ms(input int fast_hi, input int max_hi);
		int sel;
		sel = $urandom_range(9);
		if (sel < 2)
			return 0;
		else if (sel < 9)
			return $urandom_range(fast_hi, 1);
		else
			return $urandom_range(max_hi, 1);
	endfunction

	// Reset settings: idle tick, report-only word, slow attack, tiny release step.
	task automatic test_defaults();
		send_word(4'd0, OP_TICK, 1'b0);
		send_word(4'd15, OP_IGNORE, 1'b1);
		send_word(4'd0, OP_NOTE_ON, 1'b0);
		send_word(4'd0, OP_TICK, 1'b0);
		send_word(4'd0, OP_TICK, 1'b1);
		send_word(4'd0, OP_IGNORE, 1'b0);
		send_word(4'd0, OP_NOTE_OFF, 1'b1);
		send_word(4'd0, OP_TICK, 1'b1);
		send_word(4'd9, OP_NOTE_OFF, 1'b0);
		send_word(4'd9, OP_TICK, 1'b0);
	endtask

	// Zero times: attack and decay jump, release waits for the waveform to reach zero.
	task automatic test_jumps();
		apply_settings('0, '0, '0, 8'd0, 8'd255);
		send_word(4'd15, OP_NOTE_ON, 1'b1);
		send_word(4'd15, OP_TICK, 1'b0);
		send_word(4'd15, OP_TICK, 1'b1);
		send_word(4'd15, OP_NOTE_ON, 1'b0);
		send_word(4'd15, OP_TICK, 1'b0);
		send_word(4'd15, OP_NOTE_OFF, 1'b0);
		send_word(4'd15, OP_TICK, 1'b0);
		send_word(4'd15, OP_TICK, 1'b0);
		send_word(4'd15, OP_TICK, 1'b1);
		send_word(4'd15, OP_TICK, 1'b1);
	endtask

	// Longest times and inverted levels: slow ramps and single-LSB steps.
	task automatic test_long_times();
		apply_settings(10'd1000, 12'd3000, 12'd3000, 8'd255, 8'd0);
		play_note(4'd6, 30, 20);
		apply_settings(10'd1, 12'd3000, 12'd3000, 8'd0, 8'd255);
		play_note(4'd10, 40, 40);
	endtask

	// The receiver holds off for a long stretch while words keep coming with no gaps.
	task automatic test_backpressure();
		apply_settings(10'd2, 12'd4, 12'd3, 8'd60, 8'd200);
		send_word(4'd3, OP_NOTE_ON, 1'b0);
		wait_idle();
		hold_request = 1'b1;
		steady_feed  = 1'b1;
		for (int i = 0; i < 12; i++)
			send_word(4'd3, OP_TICK, 1'($urandom_range(1)));
		steady_feed = 1'b0;
		wait_idle();
	endtask

	// Random settings, each played through a few whole notes with stray words mixed in.
	task automatic test_random_envelopes();
		while (words_sent < TARGET_WORDS) begin
			apply_settings(ATT_W'(pick_ms(4, 1000)), MS_W'(pick_ms(8, 3000)),
				MS_W'(pick_ms(8, 3000)), 8'($urandom_range(255)), 8'($urandom_range(255)));
			for (int n = 0; n < 4 && words_sent < TARGET_WORDS; n++)
				play_note(VOICE_W'($urandom_range(CHANNELS - 1)), $urandom_range(70),
					$urandom_range(70));
		end
	endtask

	// Result checker: each report against the oldest expectation.
	always @(posedge clk) begin
		env_report_t exp;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			reports_checked++;
			if (awaited_reports.size() == 0) begin
				record_fault($sformatf("report %0d unexpected: voice %0d level %h phase %0d",
					reports_checked, out_ch.voice_out, out_ch.level, out_ch.phase));
			end else begin
				exp = awaited_reports.pop_front();
				if (out_ch.voice_out !== exp.voice || out_ch.level !== exp.level
						|| out_ch.phase !== exp.phase)
					record_fault($sformatf("report %0d: got %0d %h %0d, expected %0d %h %0d",
						reports_checked, out_ch.voice_out, out_ch.level, out_ch.phase,
						exp.voice, exp.level, exp.phase));
			end
		end
	end

	// Receiver: segments of steady, random and patterned stalls, plus one long hold-off.
	initial begin : receiver
		int         seg_left;
		int         mode;
		logic [7:0] mask;
		seg_left = 0;
		mode     = 0;
		mask     = 8'hFF;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(3);
					seg_left = $urandom_range(200, 20);
					mask     = 8'($urandom) | 8'h01;
				end
				seg_left--;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(1));
					2: out_ch.ready <= ($urandom_range(3) == 0);
					default: begin
						out_ch.ready <= mask[0];
						mask = {mask[0], mask[7:1]};
					end
				endcase
			end
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
					|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles, %0d reports outstanding",
					quiet, awaited_reports.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin : sequencer
		arst_n             <= 1'b0;
		in_ch.valid        <= 1'b0;
		in_ch.voice        <= '0;
		in_ch.operation    <= OP_TICK;
		in_ch.wave_at_zero <= 1'b0;
		cfg_write          <= 1'b0;
		cfg_index          <= CFG_ATTACK;
		cfg_data           <= '0;
		words_sent       = 0;
		reports_checked  = 0;
		fault_count      = 0;
		settings_applied = 0;
		notes_silenced   = 0;
		burst_left       = 0;
		offering         = 1'b0;
		steady_feed      = 1'b0;
		hold_request     = 1'b0;
		att_q  = 10'd200;
		dec_q  = 12'd1000;
		rel_q  = 12'd1000;
		sus_q  = 8'd100;
		peak_q = 8'd255;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_level[i]        = '0;
			chan_phase[i]        = PH_IDLE;
			chan_release_from[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_jumps();
		test_long_times();
		test_backpressure();
		test_random_envelopes();

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d words under %0d register settings; %0d reports checked.",
			words_sent, settings_applied, reports_checked);
		$display("Notes released to silence: %0d; faults found: %0d.",
			notes_silenced, fault_count);
		if (fault_count == 0 && awaited_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
